>>> rtl/core/zcpr_pkg.sv
`timescale 1ns / 1ps

package zcpr_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int MAX_LINES    = 8;
    localparam int CHAN_BITS    = 3;
    localparam int SAMPLE_BITS  = 24;
    localparam int COUNT_BITS   = 24;
    localparam int RATE_BITS    = 19;
    localparam int Q_BITS       = 8;
    localparam int FREQ_BITS    = 27;

    // dividend = rate*256 + period/2, one bit wider than the larger term
    localparam int NUM_A    = RATE_BITS + Q_BITS;
    localparam int NUM_BITS = ((NUM_A > COUNT_BITS - 1) ? NUM_A : COUNT_BITS - 1) + 1;

    localparam int IN_FIELD_BITS  = CHAN_BITS + SAMPLE_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int LINE_DATA_BITS = CHAN_BITS + 1 + 2 * COUNT_BITS + 2 * FREQ_BITS;
    localparam int OUT_DATA_BITS  = ((LINE_DATA_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [RATE_BITS-1:0]  RATE_RESET = RATE_BITS'(44100);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic                   report;
        logic [CHAN_BITS-1:0]   chan;
        logic [SAMPLE_BITS-1:0] sample;
    } t_op;

    typedef struct packed {
        logic                  last;
        logic [FREQ_BITS-1:0]  low_freq;
        logic [FREQ_BITS-1:0]  high_freq;
        logic [COUNT_BITS-1:0] longest;
        logic [COUNT_BITS-1:0] shortest;
        logic                  found;
        logic [CHAN_BITS-1:0]  chan;
    } t_line;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_LOAD,
        BK_DIV
    } t_back_state;

endpackage

>>> rtl/core/zero_crossing_period_range_unit.sv
`timescale 1ns / 1ps
// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: channel, sample; tuser: action
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: report line; tlast: last line
// cfg       | in  | i_cfg_valid / o_cfg_ready     | sample_rate
//
// A sample item is applied as the back end pops it; samples stream at one per cycle
// while the queue is not full. A report item yields one line per channel, up to eight,
// each from the bit-serial dividers (two in parallel); no item is popped meanwhile.
// Reset clears all channel state and loads sample_rate 44100; no clearing pass.
// A two-item queue sits between front and back, so input keeps flowing while
// the output is stalled, until the queue fills.

module zero_crossing_period_range_unit
    import zcpr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // channel[2:0], sample[26:3]
    input  logic                     s_axis_tuser,   // action

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // out_channel, found, shortest_period, longest_period,
    // highest_freq_q8, lowest_freq_q8
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                     m_axis_tlast,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [RATE_BITS-1:0]     i_cfg_data
);

    logic [RATE_BITS-1:0] r_rate;

    logic  w_push;
    logic  w_pop;
    logic  w_q_full;
    logic  w_q_valid;
    t_op   w_in_op;
    t_op   w_q_op;
    t_line w_line;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_rate <= i_cfg_data;
        end
    end

    zcpr_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_tvalid (s_axis_tvalid),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_q_full (w_q_full),
        .o_tready (s_axis_tready),
        .o_push   (w_push),
        .o_op     (w_in_op)
    );

    zcpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_op),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_op)
    );

    zcpr_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_q_valid),
        .i_op        (w_q_op),
        .o_pop       (w_pop),
        .i_rate      (r_rate),
        .o_out_valid (m_axis_tvalid),
        .o_out       (w_line),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = OUT_DATA_BITS'({w_line.low_freq, w_line.high_freq,
                                          w_line.longest, w_line.shortest,
                                          w_line.found, w_line.chan});
    assign m_axis_tlast = w_line.last;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("back end popped an empty queue");

    a_found_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_line.found == (w_line.shortest != '0)))
        else $error("found flag disagrees with shortest period");

    a_last_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (int'(w_line.chan) == ((CHANNELS < MAX_LINES) ? CHANNELS : MAX_LINES) - 1))
        else $error("last flag on a line other than the final channel");

endmodule

>>> rtl/core/zcpr_front.sv
`timescale 1ns / 1ps

module zcpr_front
    import zcpr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                    i_tvalid,
    input  logic [IN_DATA_BITS-1:0] i_tdata,
    input  logic                    i_tuser,
    input  logic                    i_q_full,
    output logic                    o_tready,
    output logic                    o_push,
    output t_op                     o_op
);

    logic w_keep;

    always_comb begin
        o_op.report = i_tuser;
        o_op.chan   = i_tdata[CHAN_BITS-1:0];
        o_op.sample = i_tdata[IN_FIELD_BITS-1:CHAN_BITS];
    end

    // samples for channels beyond the configured count are taken and dropped
    assign w_keep   = i_tuser || (int'(o_op.chan) < CHANNELS);
    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && o_tready && w_keep;

endmodule

>>> rtl/core/zcpr_queue.sv
`timescale 1ns / 1ps

module zcpr_queue
    import zcpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_data
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_op                 r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wp;
    logic [PTR_BITS-1:0] r_rp;
    logic [CNT_BITS-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/zcpr_div.sv
`timescale 1ns / 1ps

module zcpr_div
    import zcpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_BITS-1:0]   i_num,
    input  logic [COUNT_BITS-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_BITS-1:0]   o_quo
);

    localparam int LEFT_BITS = $clog2(NUM_BITS + 1);

    logic [LEFT_BITS-1:0]  r_left;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [NUM_BITS-1:0]   r_quo;
    logic [COUNT_BITS:0]   w_rem_sh;
    logic [COUNT_BITS+1:0] w_diff;

    // restoring division, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_quo[NUM_BITS-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign o_busy   = (r_left != '0);
    assign o_quo    = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (o_busy) begin
            r_quo <= {r_quo[NUM_BITS-2:0], ~w_diff[COUNT_BITS+1]};
            if (!w_diff[COUNT_BITS+1]) begin
                r_rem <= w_diff[COUNT_BITS-1:0];
            end else begin
                r_rem <= w_rem_sh[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_start) begin
            r_left <= LEFT_BITS'(NUM_BITS);
        end else if (o_busy) begin
            r_left <= r_left - 1'b1;
        end
    end

endmodule

>>> rtl/core/zcpr_back.sv
`timescale 1ns / 1ps

module zcpr_back
    import zcpr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_op_valid,
    input  t_op                  i_op,
    output logic                 o_pop,
    input  logic [RATE_BITS-1:0] i_rate,
    output logic                 o_out_valid,
    output t_line                o_out,
    input  logic                 i_out_ready
);

    localparam int LINES = (CHANNELS < MAX_LINES) ? CHANNELS : MAX_LINES;
    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

    logic [SAMPLE_BITS-1:0] r_prev  [LINES];
    logic [COUNT_BITS-1:0]  r_cnt   [LINES];
    logic [COUNT_BITS-1:0]  r_min   [LINES];
    logic [COUNT_BITS-1:0]  r_max   [LINES];
    logic                   r_dir   [LINES];
    logic                   r_first [LINES];
    logic [LINES-1:0]       r_vld;

    t_back_state r_state;
    t_back_state n_state;
    logic [IDX_W-1:0] r_line;
    logic             r_out_valid;
    t_line            r_out;

    logic [IDX_W-1:0]       w_addr;
    logic                   e_vld;
    logic [SAMPLE_BITS-1:0] e_prev;
    logic [COUNT_BITS-1:0]  e_cnt;
    logic [COUNT_BITS-1:0]  e_min;
    logic [COUNT_BITS-1:0]  e_max;
    logic                   e_dir;
    logic                   e_first;

    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] n_min;
    logic [COUNT_BITS-1:0] n_max;
    logic                  n_dir;
    logic                  n_first;
    logic [COUNT_BITS-1:0] w_cnt1;
    logic                  w_cross;
    logic                  w_up;
    logic                  w_down;

    logic                w_wr;
    logic                w_div_start;
    logic                w_load;
    logic                w_last;
    logic                w_busy_min;
    logic                w_busy_max;
    logic [NUM_BITS-1:0] w_num_base;
    logic [NUM_BITS-1:0] w_quo_min;
    logic [NUM_BITS-1:0] w_quo_max;
    t_line               w_line;

    // one read port: the sample's channel while running, the line while reporting
    assign w_addr = (r_state == BK_RUN) ? i_op.chan[IDX_W-1:0] : r_line;

    // an entry never written since reset or report reads as its reset value
    assign e_vld   = r_vld[w_addr];
    assign e_prev  = e_vld ? r_prev[w_addr]  : '0;
    assign e_cnt   = e_vld ? r_cnt[w_addr]   : COUNT_BITS'(1);
    assign e_min   = e_vld ? r_min[w_addr]   : '0;
    assign e_max   = e_vld ? r_max[w_addr]   : '0;
    assign e_dir   = e_vld ? r_dir[w_addr]   : 1'b1;
    assign e_first = e_vld ? r_first[w_addr] : 1'b0;

    assign w_cnt1  = (e_cnt != COUNT_MAX) ? e_cnt + 1'b1 : e_cnt;
    assign w_up    = $signed(i_op.sample) > $signed(e_prev);
    assign w_down  = $signed(i_op.sample) < $signed(e_prev);
    assign w_cross = ($signed(e_prev) <= 0 && $signed(i_op.sample) >= 0) ||
                     ($signed(e_prev) >= 0 && $signed(i_op.sample) <= 0);

    always_comb begin
        n_cnt   = e_cnt;
        n_min   = e_min;
        n_max   = e_max;
        n_dir   = e_dir;
        n_first = e_first;
        if (e_vld) begin
            n_cnt = w_cnt1;
            if (w_cross) begin
                if (e_first) begin
                    if ((e_dir && w_up) || (!e_dir && w_down)) begin
                        if (w_cnt1 < e_min || e_min == '0) begin
                            n_min = w_cnt1;
                        end
                        if (w_cnt1 > e_max || e_max == '0) begin
                            n_max = w_cnt1;
                        end
                        n_cnt = '0;
                    end
                end else begin
                    n_first = 1'b1;
                    n_dir   = w_up;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_RUN: begin
                if (i_op_valid && i_op.report) begin
                    n_state = BK_LOAD;
                end
            end
            BK_LOAD: begin
                n_state = BK_DIV;
            end
            BK_DIV: begin
                if (w_load) begin
                    n_state = w_last ? BK_RUN : BK_LOAD;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop       = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            BK_RUN: begin
                o_pop = i_op_valid;
            end
            BK_LOAD: begin
                w_div_start = 1'b1;
            end
            BK_DIV: begin
                w_load = !w_busy_min && !w_busy_max && (!r_out_valid || i_out_ready);
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign w_wr   = o_pop && !i_op.report;
    assign w_last = (r_line == IDX_W'(LINES - 1));

    // rounded: (rate*256 + period/2) / period
    assign w_num_base = NUM_BITS'({i_rate, {Q_BITS{1'b0}}});

    zcpr_div u_div_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_base + NUM_BITS'(e_min >> 1)),
        .i_den   (e_min),
        .o_busy  (w_busy_min),
        .o_quo   (w_quo_min)
    );

    zcpr_div u_div_max (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_base + NUM_BITS'(e_max >> 1)),
        .i_den   (e_max),
        .o_busy  (w_busy_max),
        .o_quo   (w_quo_max)
    );

    always_comb begin
        w_line.chan      = CHAN_BITS'(r_line);
        w_line.found     = (e_min != '0);
        w_line.shortest  = e_min;
        w_line.longest   = e_max;
        w_line.high_freq = (e_min == '0) ? '0 : w_quo_min[FREQ_BITS-1:0];
        w_line.low_freq  = (e_max == '0) ? '0 : w_quo_max[FREQ_BITS-1:0];
        w_line.last      = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_prev[w_addr]  <= i_op.sample;
            r_cnt[w_addr]   <= n_cnt;
            r_min[w_addr]   <= n_min;
            r_max[w_addr]   <= n_max;
            r_dir[w_addr]   <= n_dir;
            r_first[w_addr] <= n_first;
        end
        if (w_load) begin
            r_out <= w_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_line      <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr) begin
                r_vld[w_addr] <= 1'b1;
            end
            if (o_pop && i_op.report) begin
                r_line <= '0;
            end else if (w_load && !w_last) begin
                r_line <= r_line + 1'b1;
            end
            // report done: every channel back to its reset state
            if (w_load && w_last) begin
                r_vld <= '0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
